// ----- rtl/v3n_pkg.sv -----
`default_nettype none
package v3n_pkg;
  localparam int COMPONENT_BITS     = 16;
  localparam int UNIT_FRACTION_BITS = 14;
  localparam int UNIT_BITS          = UNIT_FRACTION_BITS + 2;
  localparam int SUM_BITS           = 2 * COMPONENT_BITS + 2;
  localparam int ROOT_BITS          = COMPONENT_BITS + 1;
  localparam int DIVIDEND_BITS      = COMPONENT_BITS + UNIT_FRACTION_BITS;
  localparam int QUOT_BITS          = UNIT_FRACTION_BITS + 1;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] x_in;
    logic signed [COMPONENT_BITS-1:0] y_in;
    logic signed [COMPONENT_BITS-1:0] z_in;
  } in_item_t;

  typedef struct packed {
    logic signed [UNIT_BITS-1:0]  x_unit;
    logic signed [UNIT_BITS-1:0]  y_unit;
    logic signed [UNIT_BITS-1:0]  z_unit;
    logic [COMPONENT_BITS-1:0]    magnitude;
    logic                         zero_length;
  } out_item_t;

  // What the front hands the back: magnitudes, signs and the root.
  typedef struct packed {
    logic [2:0][COMPONENT_BITS-1:0] mag;
    logic [2:0]                     neg;
    logic [ROOT_BITS-1:0]           root;
  } work_t;
endpackage
`default_nettype wire

// ----- rtl/v3n_front.sv -----
`default_nettype none
// Front: absolute values, sum of squares, then a pipelined restoring square
// root that resolves one root bit per stage.
module v3n_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire v3n_pkg::in_item_t item,
  output logic                  out_valid,
  output v3n_pkg::work_t        work
);
  localparam int CB = v3n_pkg::COMPONENT_BITS;
  localparam int SB = v3n_pkg::SUM_BITS;
  localparam int RB = v3n_pkg::ROOT_BITS;
  localparam int NS = RB;

  logic [2:0][CB-1:0] a_mag;
  logic [2:0]         a_neg;
  logic               a_valid;
  logic [2:0][2*CB-1:0] b_sq;
  logic [2:0][CB-1:0] b_mag;
  logic [2:0]         b_neg;
  logic               b_valid;

  logic [NS:0]           s_valid;
  logic [NS:0][SB-1:0]   s_rem;
  logic [NS:0][RB-1:0]   s_root;
  logic [NS:0][2:0][CB-1:0] s_mag;
  logic [NS:0][2:0]      s_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      s_valid[0] <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      s_valid[0] <= b_valid;
    end
    a_neg <= {item.z_in[CB-1], item.y_in[CB-1], item.x_in[CB-1]};
    a_mag[0] <= item.x_in[CB-1] ? CB'(-item.x_in) : CB'(item.x_in);
    a_mag[1] <= item.y_in[CB-1] ? CB'(-item.y_in) : CB'(item.y_in);
    a_mag[2] <= item.z_in[CB-1] ? CB'(-item.z_in) : CB'(item.z_in);
    for (int i = 0; i < 3; i++) b_sq[i] <= (2*CB)'(a_mag[i]) * (2*CB)'(a_mag[i]);
    b_mag <= a_mag;
    b_neg <= a_neg;
    s_rem[0]  <= SB'(b_sq[0]) + SB'(b_sq[1]) + SB'(b_sq[2]);
    s_root[0] <= '0;
    s_mag[0]  <= b_mag;
    s_neg[0]  <= b_neg;
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam int BIT = NS - 1 - k;
    logic [SB+1:0] trial;
    logic [SB+1:0] rem_w;
    assign rem_w = (SB + 2)'(s_rem[k]);
    assign trial = ((SB + 2)'(s_root[k]) << (BIT + 1)) + ((SB + 2)'(1) << (2 * BIT));
    always_ff @(posedge clk) begin
      if (rst) s_valid[k+1] <= 1'b0;
      else s_valid[k+1] <= s_valid[k];
      if (rem_w >= trial) begin
        s_rem[k+1]  <= SB'(rem_w - trial);
        s_root[k+1] <= s_root[k] | (RB'(1) << BIT);
      end else begin
        s_rem[k+1]  <= s_rem[k];
        s_root[k+1] <= s_root[k];
      end
      s_mag[k+1] <= s_mag[k];
      s_neg[k+1] <= s_neg[k];
    end
  end

  assign out_valid = s_valid[NS];
  assign work.mag  = s_mag[NS];
  assign work.neg  = s_neg[NS];
  assign work.root = s_root[NS];
endmodule
`default_nettype wire

// ----- rtl/v3n_queue.sv -----
`default_nettype none
// Short register queue between the square-root front and the divider back.
module v3n_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire v3n_pkg::work_t push_data,
  output logic                pop_valid,
  output v3n_pkg::work_t      pop_data
);
  always_ff @(posedge clk) begin
    if (rst) pop_valid <= 1'b0;
    else pop_valid <= push;
    pop_data <= push_data;
  end
endmodule
`default_nettype wire

// ----- rtl/v3n_back.sv -----
`default_nettype none
// Back: three pipelined restoring dividers, one quotient bit per stage, then
// sign restore and output register.
module v3n_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire v3n_pkg::work_t work,
  output logic                done,
  output v3n_pkg::out_item_t  result
);
  localparam int CB = v3n_pkg::COMPONENT_BITS;
  localparam int RB = v3n_pkg::ROOT_BITS;
  localparam int QB = v3n_pkg::QUOT_BITS;
  localparam int DB = v3n_pkg::DIVIDEND_BITS;
  localparam int UB = v3n_pkg::UNIT_BITS;

  logic [QB:0]                d_valid;
  logic [QB:0][2:0][DB-1:0]   d_rem;
  logic [QB:0][2:0][QB-1:0]   d_quo;
  logic [QB:0][RB-1:0]        d_root;
  logic [QB:0][2:0]           d_neg;

  always_ff @(posedge clk) begin
    if (rst) d_valid[0] <= 1'b0;
    else d_valid[0] <= in_valid;
    for (int i = 0; i < 3; i++) begin
      d_rem[0][i] <= DB'(work.mag[i]) << v3n_pkg::UNIT_FRACTION_BITS;
      d_quo[0][i] <= '0;
    end
    d_root[0] <= work.root;
    d_neg[0]  <= work.neg;
  end

  // Quotient never exceeds 2**UNIT_FRACTION_BITS, so QB bits suffice.
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BIT = QB - 1 - k;
    always_ff @(posedge clk) begin
      if (rst) d_valid[k+1] <= 1'b0;
      else d_valid[k+1] <= d_valid[k];
      for (int i = 0; i < 3; i++) begin
        if ((d_rem[k][i] >> BIT) >= (DB)'(d_root[k])) begin
          d_rem[k+1][i] <= d_rem[k][i] - ((DB)'(d_root[k]) << BIT);
          d_quo[k+1][i] <= d_quo[k][i] | (QB'(1) << BIT);
        end else begin
          d_rem[k+1][i] <= d_rem[k][i];
          d_quo[k+1][i] <= d_quo[k][i];
        end
      end
      d_root[k+1] <= d_root[k];
      d_neg[k+1]  <= d_neg[k];
    end
  end

  logic [2:0][UB-1:0] unit;
  logic               is_zero;
  assign is_zero = (d_root[QB] == '0);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit[i] = is_zero ? '0 : (d_neg[QB][i] ? UB'(-UB'(d_quo[QB][i]))
                                             : UB'(d_quo[QB][i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= d_valid[QB];
    result.x_unit      <= unit[0];
    result.y_unit      <= unit[1];
    result.z_unit      <= unit[2];
    result.magnitude   <= CB'(d_root[QB]);
    result.zero_length <= is_zero;
  end

  zero_flag_implies_zero_units: assert property (@(posedge clk) disable iff (rst)
    done && result.zero_length |-> result.x_unit == '0 && result.y_unit == '0
      && result.z_unit == '0)
    else $error("zero-length beat carries nonzero components");
  zero_flag_matches_magnitude: assert property (@(posedge clk) disable iff (rst)
    done |-> result.zero_length == (result.magnitude == '0))
    else $error("zero flag disagrees with magnitude");
  divider_feeds_output: assert property (@(posedge clk) disable iff (rst)
    d_valid[QB] |=> done)
    else $error("divider beat lost at output");
endmodule
`default_nettype wire

// ----- rtl/vector3_normalize.sv -----
`default_nettype none
// Path from the start edge to the done beat: the front registers for absolute
// value, squares and sum, then 17 square-root stages, 1 queue stage, 1 load,
// 15 divide stages, 1 out.
// Throughput: one vector per cycle; busy is always low, set by the fully
// pipelined square-root and divider stages. Results cannot be stalled.
// Reset: synchronous, active high; clears all valid bits so no beat is in flight.
module vector3_normalize (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire v3n_pkg::in_item_t   item,
  output logic                     done,
  output v3n_pkg::out_item_t       result
);
  // The front accepts a beat every cycle, so busy never rises.
  assign busy = 1'b0;

  logic           f_valid;
  v3n_pkg::work_t f_work;
  logic           q_valid;
  v3n_pkg::work_t q_work;

  // Front: absolute values, sum of squares and floored square root.
  v3n_front u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .item(item),
    .out_valid(f_valid), .work(f_work)
  );

  // Queue stage that decouples the root pipeline from the dividers.
  v3n_queue u_queue (
    .clk(clk), .rst(rst), .push(f_valid), .push_data(f_work),
    .pop_valid(q_valid), .pop_data(q_work)
  );

  // Back: component divided by length, sign restored, registered out.
  v3n_back u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .work(q_work),
    .done(done), .result(result)
  );
endmodule
`default_nettype wire

// ----- tb/tb_vector3_normalize.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_vector3_normalize;

  // The block is a fully pipelined normalizer: a vector beat enters on start
  // while busy is low, and one result beat later leaves on done for it.
  // It has no registers to configure, so the run is directed rows followed by
  // three random phases that differ only in how often the sender idles.
  localparam int LATENCY     = 38;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT = 200000;

  // One stimulus row. When has_want is set the expected beat is typed in and
  // is checked against the predictor as well, so a wrong row is caught too.
  typedef struct {
    logic signed [15:0] x, y, z;
    bit                 has_want;
    v3n_pkg::out_item_t want;
  } row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  v3n_pkg::in_item_t  item;
  logic               done;
  v3n_pkg::out_item_t result;

  v3n_pkg::out_item_t pending_units[$];
  int        mismatches;
  int        beats_in;
  int        beats_out;
  int        zero_seen;
  longint    cycles;
  int        sender_idle_pct;
  row_t      rows[$];

  vector3_normalize u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Floored square root by the bit-pair method, on a 64-bit accumulator.
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Normalize one vector: length is the floored root of the sum of squares,
  // each component is divided by it with truncation toward zero, in Q1.14.
  function automatic v3n_pkg::out_item_t normalize(v3n_pkg::in_item_t v);
    v3n_pkg::out_item_t r;
    longint          comp[3];
    longint unsigned mag[3];
    longint unsigned sum;
    longint unsigned len;
    longint unsigned q;
    logic [15:0]     u[3];
    comp[0] = v.x_in;
    comp[1] = v.y_in;
    comp[2] = v.z_in;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (comp[i] < 0) ? -comp[i] : comp[i];
      sum += mag[i] * mag[i];
    end
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        u[i] = '0;
      end else begin
        q = (mag[i] << v3n_pkg::UNIT_FRACTION_BITS) / len;
        u[i] = (comp[i] < 0) ? 16'(-q) : 16'(q);
      end
    end
    r.x_unit      = u[0];
    r.y_unit      = u[1];
    r.z_unit      = u[2];
    r.magnitude   = len[15:0];
    r.zero_length = (len == 0);
    return r;
  endfunction

  function automatic void report(string what, v3n_pkg::out_item_t want,
                                 v3n_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch %s at beat %0d: want x=%0d y=%0d z=%0d m=%0d zl=%0b",
                " got x=%0d y=%0d z=%0d m=%0d zl=%0b"},
               what, beats_out, want.x_unit, want.y_unit, want.z_unit, want.magnitude,
               want.zero_length, got.x_unit, got.y_unit, got.z_unit, got.magnitude,
               got.zero_length);
  endfunction

  // Result side: every done beat is compared field by field with the oldest
  // expectation. Sampling happens at the rising edge while the driver only
  // moves inputs at the falling edge, so there is no race.
  always @(posedge clk) begin
    v3n_pkg::out_item_t want;
    cycles++;
    if (!rst && done) begin
      if (pending_units.size() == 0) begin
        report("unexpected", '0, result);
      end else begin
        want = pending_units.pop_front();
        if (result.x_unit !== want.x_unit || result.y_unit !== want.y_unit ||
            result.z_unit !== want.z_unit || result.magnitude !== want.magnitude ||
            result.zero_length !== want.zero_length)
          report("field", want, result);
        if (result.zero_length === 1'b1) zero_seen++;
      end
      beats_out++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drive one beat: hold start high from a falling edge until a rising edge
  // sees busy low. Start stays high if another beat follows without a gap.
  task automatic send_beat(v3n_pkg::in_item_t v);
    v3n_pkg::out_item_t want;
    item  <= v;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    want = normalize(v);
    pending_units.push_back(want);
    beats_in++;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  function automatic logic signed [15:0] pick_component();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return 16'($signed($urandom_range(0, 32)) - 16);
      4: return 16'($urandom_range(0, 2047)) - 16'sd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_row(int x, int y, int z, bit has, v3n_pkg::out_item_t w);
    row_t r;
    r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
    r.has_want = has;
    r.want = w;
    rows.push_back(r);
  endfunction

  initial begin
    v3n_pkg::in_item_t  v;
    v3n_pkg::out_item_t w;
    rst = 1'b1; start = 1'b0; item = '0;
    mismatches = 0; beats_in = 0; beats_out = 0; zero_seen = 0; cycles = 0;
    sender_idle_pct = 0;

    // Directed rows. Zero length raises the flag with zero components; a lone
    // axis component reads exactly one unit; the most negative value and the
    // all-extreme corners cover the widest lengths.
    add_row(0, 0, 0, 1, '{16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1});
    add_row(256, 0, 0, 1, '{16'sd16384, 16'sd0, 16'sd0, 16'd256, 1'b0});
    add_row(0, -256, 0, 1, '{16'sd0, -16'sd16384, 16'sd0, 16'd256, 1'b0});
    add_row(0, 0, 1, 1, '{16'sd0, 16'sd0, 16'sd16384, 16'd1, 1'b0});
    add_row(-32768, 0, 0, 1, '{-16'sd16384, 16'sd0, 16'sd0, 16'd32768, 1'b0});
    add_row(0, 32767, 0, 1, '{16'sd0, 16'sd16384, 16'sd0, 16'd32767, 1'b0});
    add_row(-32768, -32768, -32768, 0, '0);
    add_row(32767, 32767, 32767, 0, '0);
    add_row(-32768, 32767, -32768, 0, '0);
    add_row(1, 1, 1, 0, '0);
    add_row(-1, -1, -1, 0, '0);
    add_row(3, 4, 0, 0, '0);
    add_row(-1, 0, 1, 0, '0);
    add_row(12345, -6789, 1024, 0, '0);
    add_row(16'sh5555, 16'sh2aaa, -16'sh5555, 0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      v.x_in = rows[i].x; v.y_in = rows[i].y; v.z_in = rows[i].z;
      if (rows[i].has_want) begin
        w = normalize(v);
        if (w !== rows[i].want) report("table", rows[i].want, w);
      end
      send_beat(v);
    end
    start <= 1'b0;

    // Hold the sender off until every expected beat has come back once.
    while (pending_units.size() != 0) @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 71 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        v.x_in = pick_component();
        v.y_in = pick_component();
        v.z_in = pick_component();
        if ($urandom_range(49) == 0) v = '0;
        send_beat(v);
        idle_gap();
      end
    end
    start <= 1'b0;

    while (pending_units.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);

    $display("Sent %0d vectors, %0d results checked, %0d of them zero length.",
             beats_in, beats_out, zero_seen);
    $display("Sender idling covered 6, 71 and 0 percent phases; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_units.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
